// ===== sv/plist_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; plist_ctrl and the top level use this package.
`default_nettype none

package plist_pkg;

  // Default sizing of the list store
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the request and result words
  localparam int ACT_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;

  // Request codes
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Request word
  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } plist_in_t;

  // Result word
  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        found_position;
    logic [LEN_W-1:0]        length;
    logic                    empty_res;
  } plist_out_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } plist_hs_t;

endpackage

`default_nettype wire

// ===== sv/plist_ram.sv =====
// Entry store of the positional list: one write port, one read port,
// registered read data. Uses no package items.
`default_nettype none

module plist_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/plist_ctrl.sv =====
// Sequencer of the positional list: bounds checks, entry count, and the
// one-entry-per-cycle shift and search walk over the store. Uses plist_pkg.
`default_nettype none

module plist_ctrl #(
  parameter int CAPACITY   = plist_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = plist_pkg::DATA_WIDTH_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire plist_pkg::plist_in_t  req_i,
  input  wire logic                  ack_i,
  output plist_pkg::plist_out_t      res_o,
  output plist_pkg::plist_hs_t       hs_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [DATA_WIDTH-1:0]      mem_wdata_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata_i
);

  import plist_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_INS   = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_READ  = 7'b0010000,
    S_LOC   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [ACT_W-1:0]      op_q, op_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         wa_q, wa_d;
  logic [AW-1:0]         last_q, last_d;
  logic [AW-1:0]         p0_q, p0_d;
  logic                  more_q, more_d;
  logic                  pend_q, pend_d;
  logic                  cap_q, cap_d;
  logic [DATA_WIDTH-1:0] rdv_q, rdv_d;
  plist_out_t            res_q, res_d;

  // Finish request from the sequencer
  logic                  fin;
  status_e               fin_status;
  logic [VAL_W-1:0]      fin_rd;
  logic [POS_W-1:0]      fin_found;

  // Bounds arithmetic on the latched request
  logic [CMPW-1:0]       pos_x, cnt_x;
  logic [AW-1:0]         p0, cnt_m1;
  logic                  hit;

  assign pos_x  = CMPW'(pos_q);
  assign cnt_x  = CMPW'(count_q);
  assign p0     = AW'(pos_x - CMPW'(1));
  assign cnt_m1 = AW'(cnt_x - CMPW'(1));
  assign hit    = pend_q && (mem_rdata_i == word_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    word_d      = word_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    wa_d        = wa_q;
    last_d      = last_q;
    p0_d        = p0_q;
    more_d      = more_q;
    pend_d      = pend_q;
    cap_d       = cap_q;
    rdv_d       = rdv_q;
    res_d       = res_q;
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_rd      = '0;
    fin_found   = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = req_i.action;
          pos_d   = req_i.position;
          word_d  = DATA_WIDTH'(req_i.value);
          rdv_d   = '0;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        more_d = 1'b1;
        pend_d = 1'b0;
        cap_d  = 1'b0;
        p0_d   = p0;
        case (op_q)
          ACT_INSERT: begin
            if (pos_q == '0 || pos_x > cnt_x + CMPW'(1)) begin
              fin        = 1'b1;
              fin_status = ST_RANGE;
            end else if (cnt_x == CMPW'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else if (pos_x == cnt_x + CMPW'(1)) begin
              // append at the tail, nothing to shift
              mem_we_o    = 1'b1;
              mem_waddr_o = AW'(count_q);
              mem_wdata_o = word_q;
              count_d     = count_q + CW'(1);
              fin         = 1'b1;
            end else begin
              ptr_d   = cnt_m1;
              state_d = S_INS;
            end
          end
          ACT_DELETE, ACT_GET: begin
            if (pos_q == '0 || pos_x > cnt_x) begin
              fin        = 1'b1;
              fin_status = ST_RANGE;
            end else begin
              ptr_d   = p0;
              last_d  = (op_q == ACT_GET) ? p0 : cnt_m1;
              state_d = S_READ;
            end
          end
          ACT_LOCATE: begin
            if (count_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_NOTFOUND;
            end else begin
              ptr_d   = '0;
              last_d  = cnt_m1;
              state_d = S_LOC;
            end
          end
          ACT_CLEAR: begin
            count_d = '0;
            fin     = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      // shift entries up by one, walking down from the tail
      S_INS: begin
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        if (more_q) begin
          pend_d = 1'b1;
          wa_d   = ptr_q + AW'(1);
          if (ptr_q == p0_q) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q - AW'(1);
          end
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end

      // drop the new word into the opened slot
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = p0_q;
        mem_wdata_o = word_q;
        count_d     = count_q + CW'(1);
        fin         = 1'b1;
      end

      // read the target, then shift the rest down by one (delete)
      S_READ: begin
        if (pend_q) begin
          if (cap_q) begin
            rdv_d = mem_rdata_i;
          end else begin
            mem_we_o = 1'b1;
          end
        end
        if (more_q) begin
          pend_d = 1'b1;
          cap_d  = (ptr_q == p0_q);
          wa_d   = ptr_q - AW'(1);
          if (ptr_q == last_q) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end else begin
          fin    = 1'b1;
          fin_rd = VAL_W'(signed'(rdv_d));
          if (op_q == ACT_DELETE) begin
            count_d = count_q - CW'(1);
          end
        end
      end

      // walk from the head, one compare per cycle
      S_LOC: begin
        if (hit) begin
          fin       = 1'b1;
          fin_found = POS_W'(CMPW'(wa_q) + CMPW'(1));
        end else if (!more_q) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end else begin
          pend_d = 1'b1;
          wa_d   = ptr_q;
          if (ptr_q == last_q) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
      end

      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Build the result word on completion
    if (fin) begin
      state_d              = S_DONE;
      res_d.status         = fin_status;
      res_d.read_value     = fin_rd;
      res_d.found_position = fin_found;
      res_d.length         = LEN_W'(count_d);
      res_d.empty_res      = (count_d == '0);
    end
  end

  assign mem_raddr_o = ptr_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      more_q  <= 1'b0;
      pend_q  <= 1'b0;
      cap_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      more_q  <= more_d;
      pend_q  <= pend_d;
      cap_q   <= cap_d;
    end
  end

  // Request and walk registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    word_q <= word_d;
    ptr_q  <= ptr_d;
    wa_q   <= wa_d;
    last_q <= last_d;
    p0_q   <= p0_d;
    rdv_q  <= rdv_d;
    res_q  <= res_d;
  end

  assign res_o   = res_q;
  assign hs_o.idle = (state_q == S_IDLE);
  assign hs_o.done = (state_q == S_DONE);

endmodule

`default_nettype wire

// ===== sv/positional_list_engine.sv =====
// Top level of the positional list engine: request intake, result register,
// sequencer and entry store. Uses plist_pkg, plist_ctrl and plist_ram.
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o  | plist_in_t
//   out     | output    | out_valid_o / out_stall_i| plist_out_t
//
// One request at a time. Insert with a shift and delete walk the entries at or
// after the position, get reads one entry and locate walks from the head up to
// the length; append, clear and errors need no walk. The store's single read
// and single write port set one entry per cycle.
// Reset empties the list at once; the store itself is not cleared.
// A result waiting on out_stall_i does not block the next request.
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY   = plist_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = plist_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire plist_pkg::plist_in_t in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output plist_pkg::plist_out_t     out_data_o
);

  import plist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  plist_hs_t             hs;
  plist_out_t            res;
  logic                  start, ack;
  logic                  out_valid_q;
  plist_out_t            out_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  // Intake: one request while the sequencer is idle
  assign in_stall_o = !hs.idle;
  assign start      = in_valid_i && hs.idle;

  // Hand the finished result to the output register when it is free
  assign ack = hs.done && (!out_valid_q || !out_stall_i);

  plist_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (in_data_i),
    .ack_i      (ack),
    .res_o      (res),
    .hs_o       (hs),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  plist_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
